>>> hw/rtl/go_back_n_sender_window_core_macros.svh
// ----------------------------------------------------------------------------
// Go-back-N sender window: assertion macros
// Shared concurrent assertion forms, clocked on i_clk and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef GO_BACK_N_SENDER_WINDOW_CORE_MACROS_SVH
`define GO_BACK_N_SENDER_WINDOW_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GBNSW_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GBNSW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/gbnsw_pkg.sv
// ----------------------------------------------------------------------------
// Go-back-N sender window package
// Field widths, codes, default parameter values and shared structures.
// ----------------------------------------------------------------------------
package gbnsw_pkg;

    localparam int SEQ_W       = 14;
    localparam int TIMER_W     = 32;
    localparam int MSG_LEN_W   = 25;
    localparam int OFFSET_W    = 24;
    localparam int SEND_LEN_W  = 11;
    localparam int ACK_SEQ_W   = 32;
    localparam int ACK_TYPE_W  = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_ADDR_W  = 4;
    localparam int REG_IDX_W   = 2;

    localparam int unsigned SEGMENT_BYTES_DEF     = 32'd1461;
    localparam int unsigned MAX_MESSAGE_BYTES_DEF = 32'd16777216;
    localparam logic [TIMER_W-1:0] TIMEOUT_RESET  = 32'd100000;

    // Request kinds.
    localparam logic REQ_BEGIN = 1'b0;
    localparam logic REQ_TICK  = 1'b1;

    // Received packet type that carries a cumulative acknowledgement.
    localparam logic [ACK_TYPE_W-1:0] ACK_PACKET = 2'd3;

    // Configuration register indexes.
    localparam logic [REG_IDX_W-1:0] REG_MAX_OUTSTANDING = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_TIMEOUT_TICKS   = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_MESSAGE_LENGTH  = 2'd2;

    typedef struct packed {
        logic [SEQ_W-1:0]     max_outstanding;
        logic [TIMER_W-1:0]   timeout_ticks;
        logic [MSG_LEN_W-1:0] message_length;
    } t_cfg;

    typedef struct packed {
        logic                  req_type;
        logic                  ack_valid;
        logic [ACK_TYPE_W-1:0] ack_type;
        logic [ACK_SEQ_W-1:0]  ack_seq;
    } t_req;

    typedef struct packed {
        logic                  send_valid;
        logic [SEQ_W-1:0]      send_seq;
        logic [OFFSET_W-1:0]   send_offset;
        logic [SEND_LEN_W-1:0] send_length;
        logic                  timed_out;
        logic                  finished;
        logic [SEQ_W-1:0]      end_seq;
    } t_rsp;

endpackage

>>> hw/rtl/gbnsw_ifs.sv
// ----------------------------------------------------------------------------
// Go-back-N sender window channel interfaces
// Valid/ready request and result channels with their payload fields.
// ----------------------------------------------------------------------------
interface gbnsw_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic        ack_valid;
    logic [1:0]  ack_type;
    logic [31:0] ack_seq;

    modport source (output valid, req_type, ack_valid, ack_type, ack_seq, input ready);
    modport sink   (input valid, req_type, ack_valid, ack_type, ack_seq, output ready);
endinterface

interface gbnsw_rsp_if;
    logic        valid;
    logic        ready;
    logic        send_valid;
    logic [13:0] send_seq;
    logic [23:0] send_offset;
    logic [10:0] send_length;
    logic        timed_out;
    logic        finished;
    logic [13:0] end_seq;

    modport source (output valid, send_valid, send_seq, send_offset, send_length,
                    timed_out, finished, end_seq, input ready);
    modport sink   (input valid, send_valid, send_seq, send_offset, send_length,
                    timed_out, finished, end_seq, output ready);
endinterface

>>> hw/rtl/gbnsw_cfg_regs.sv
// ----------------------------------------------------------------------------
// Go-back-N sender window configuration registers
// APB-style register file holding window size, timeout and message length.
// ----------------------------------------------------------------------------
module gbnsw_cfg_regs
    import gbnsw_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    logic [SEQ_W-1:0]     r_max_outstanding;
    logic [TIMER_W-1:0]   r_timeout_ticks;
    logic [MSG_LEN_W-1:0] r_message_length;
    logic [REG_IDX_W-1:0] w_idx;
    logic                 w_wr;

    assign pready = 1'b1;
    assign w_idx  = paddr[CFG_ADDR_W-1:2];
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_outstanding <= '0;
            r_timeout_ticks   <= TIMEOUT_RESET;
            r_message_length  <= '0;
        end else if (w_wr) begin
            case (w_idx)
                REG_MAX_OUTSTANDING: r_max_outstanding <= pwdata[SEQ_W-1:0];
                REG_TIMEOUT_TICKS:   r_timeout_ticks   <= pwdata[TIMER_W-1:0];
                REG_MESSAGE_LENGTH:  r_message_length  <= pwdata[MSG_LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_MAX_OUTSTANDING: prdata = CFG_DATA_W'(r_max_outstanding);
            REG_TIMEOUT_TICKS:   prdata = CFG_DATA_W'(r_timeout_ticks);
            REG_MESSAGE_LENGTH:  prdata = CFG_DATA_W'(r_message_length);
            default:             prdata = '0;
        endcase
    end

    assign o_cfg.max_outstanding = r_max_outstanding;
    assign o_cfg.timeout_ticks   = r_timeout_ticks;
    assign o_cfg.message_length  = r_message_length;

endmodule

>>> hw/rtl/gbnsw_window.sv
// ----------------------------------------------------------------------------
// Go-back-N sender window state
// Holds base, next, highest sent, timer and done; works out one request.
// ----------------------------------------------------------------------------
module gbnsw_window
    import gbnsw_pkg::*;
#(
    parameter int unsigned SEGMENT_BYTES     = SEGMENT_BYTES_DEF,
    parameter int unsigned MAX_MESSAGE_BYTES = MAX_MESSAGE_BYTES_DEF
)
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_step,
    input  t_req i_req,
    input  t_cfg i_cfg,
    output t_rsp o_rsp
);

    `include "go_back_n_sender_window_core_macros.svh"

    localparam int SEG_W  = $clog2(SEGMENT_BYTES + 1);
    localparam int PROD_W = SEQ_W + SEG_W;
    localparam int CMP_W  = (PROD_W > MSG_LEN_W) ? PROD_W : MSG_LEN_W;
    localparam logic [32:0]       MAX_EXT = 33'(MAX_MESSAGE_BYTES);
    localparam logic [CMP_W-1:0]  SEG_CMP = CMP_W'(SEGMENT_BYTES);
    localparam logic [PROD_W-1:0] SEG_MUL = PROD_W'(SEGMENT_BYTES);

    logic [SEQ_W-1:0]   r_base, n_base;
    logic [SEQ_W-1:0]   r_next, n_next;
    logic [SEQ_W-1:0]   r_high, n_high;
    logic [TIMER_W-1:0] r_timer, n_timer;
    logic               r_done, n_done;

    logic [MSG_LEN_W-1:0] w_len;
    logic [TIMER_W-1:0]   w_timer_inc;
    logic                 w_timeout;
    logic [PROD_W-1:0]    w_off;
    logic [CMP_W-1:0]     w_rem;
    logic [CMP_W-1:0]     w_slen;
    logic [SEQ_W-1:0]     w_outst;
    logic                 w_send;
    logic [SEQ_W-1:0]     w_next_inc;
    logic [SEQ_W-1:0]     w_next_a;
    logic [SEQ_W-1:0]     w_high_a;
    logic                 w_ack_ok;
    logic [SEQ_W-1:0]     w_ack_base;
    logic [PROD_W-1:0]    w_base_bytes;

    // Message length saturates at the largest supported message.
    assign w_len = (33'(i_cfg.message_length) > MAX_EXT) ? MSG_LEN_W'(MAX_MESSAGE_BYTES)
                                                        : i_cfg.message_length;

    assign w_timer_inc = (&r_timer) ? r_timer : r_timer + 1'b1;
    assign w_timeout   = (w_timer_inc >= i_cfg.timeout_ticks);

    assign w_off   = PROD_W'(r_next) * SEG_MUL;
    assign w_rem   = CMP_W'(w_len) - CMP_W'(w_off);
    assign w_slen  = (w_rem < SEG_CMP) ? w_rem : SEG_CMP;
    assign w_outst = r_next - r_base;
    assign w_send  = !w_timeout && (CMP_W'(w_off) < CMP_W'(w_len))
                     && (w_outst < i_cfg.max_outstanding);

    assign w_next_inc = r_next + 1'b1;
    assign w_next_a   = w_send ? w_next_inc : (w_timeout ? r_base : r_next);
    assign w_high_a   = (w_send && (w_next_inc > r_high)) ? w_next_inc : r_high;

    // An acknowledgement counts only when it moves base and stays within what was sent.
    assign w_ack_ok = i_req.ack_valid && (i_req.ack_type == ACK_PACKET)
                      && (i_req.ack_seq > ACK_SEQ_W'(r_base))
                      && (i_req.ack_seq <= ACK_SEQ_W'(w_high_a));
    assign w_ack_base   = i_req.ack_seq[SEQ_W-1:0];
    assign w_base_bytes = PROD_W'(w_ack_base) * SEG_MUL;

    always_comb begin
        n_base  = r_base;
        n_next  = r_next;
        n_high  = r_high;
        n_timer = r_timer;
        n_done  = r_done;
        o_rsp   = '0;
        if (i_req.req_type == REQ_BEGIN) begin
            n_base  = '0;
            n_next  = '0;
            n_high  = '0;
            n_timer = '0;
            n_done  = (w_len == '0);
        end else if (!r_done) begin
            n_timer         = w_timeout ? '0 : w_timer_inc;
            n_next          = w_next_a;
            n_high          = w_high_a;
            o_rsp.timed_out = w_timeout;
            if (w_send) begin
                o_rsp.send_valid  = 1'b1;
                o_rsp.send_seq    = r_next;
                o_rsp.send_offset = w_off[OFFSET_W-1:0];
                o_rsp.send_length = w_slen[SEND_LEN_W-1:0];
            end
            if (w_ack_ok) begin
                n_base = w_ack_base;
                if (w_next_a < w_ack_base) begin
                    n_next = w_ack_base;
                end
                if (CMP_W'(w_base_bytes) >= CMP_W'(w_len)) begin
                    n_done = 1'b1;
                end
            end
        end
        o_rsp.finished = n_done;
        o_rsp.end_seq  = n_done ? n_next : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= '0;
            r_next  <= '0;
            r_high  <= '0;
            r_timer <= '0;
            r_done  <= 1'b0;
        end else if (i_step) begin
            r_base  <= n_base;
            r_next  <= n_next;
            r_high  <= n_high;
            r_timer <= n_timer;
            r_done  <= n_done;
        end
    end

    `GBNSW_ASSERT_NEXT(a_begin_clears, i_step && (i_req.req_type == REQ_BEGIN), (r_base == '0) && (r_next == '0) && (r_timer == '0), "begin request left window state uncleared")
    `GBNSW_ASSERT_NEXT(a_done_freezes, i_step && r_done && (i_req.req_type == REQ_TICK), r_done && $stable(r_next) && $stable(r_base), "window state moved after completion")
    `GBNSW_ASSERT_SAME(a_send_excl, o_rsp.send_valid, !o_rsp.timed_out && !r_done, "segment ordered on a go-back or after completion")
    `GBNSW_ASSERT_NEXT(a_timeout_clr, i_step && o_rsp.timed_out, r_timer == '0, "timer not cleared by a go-back")

endmodule

>>> hw/rtl/go_back_n_sender_window_core.sv
// ----------------------------------------------------------------------------
// Go-back-N sender window core: input register, window logic and output register.
// One request per cycle while results are taken; the window state loop closes with no bubble.
// Synchronous active-low reset clears all window state and the valid flags of both stages.
// ----------------------------------------------------------------------------
module go_back_n_sender_window_core
    import gbnsw_pkg::*;
#(
    parameter int unsigned SEGMENT_BYTES     = SEGMENT_BYTES_DEF,
    parameter int unsigned MAX_MESSAGE_BYTES = MAX_MESSAGE_BYTES_DEF
)
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    gbnsw_req_if.sink             i_req,
    gbnsw_rsp_if.source           o_rsp,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    // The block is a two-stage pipeline. A request accepted on the input
    // channel lands in the input register. Once the output register is free the window
    // logic works it out against the current state, the state registers take
    // their new values and the result lands in the output register, all at
    // the same edge. The next request therefore sees the state left by the
    // previous one with no bubble in between.
    //
    // The output register parts the two channels: the input stage advances
    // whenever the output register is empty or is being emptied. While a
    // result waits, the request behind it is held in the input register and
    // the input channel stalls until the result is taken.

    t_cfg w_cfg;
    t_req r_in;
    logic r_in_vld;
    t_rsp r_out;
    logic r_out_vld;
    t_rsp w_res;
    logic w_out_free;
    logic w_step;
    logic w_in_ready;

    gbnsw_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    gbnsw_window #(
        .SEGMENT_BYTES     (SEGMENT_BYTES),
        .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
    ) u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_req   (r_in),
        .i_cfg   (w_cfg),
        .o_rsp   (w_res)
    );

    // The request in the input register moves on whenever the result slot is
    // free or its occupant is being taken in this cycle.
    assign w_out_free = !r_out_vld || o_rsp.ready;
    assign w_step     = r_in_vld && w_out_free;
    assign w_in_ready = !r_in_vld || w_step;
    assign i_req.ready = w_in_ready;

    // Input register. The payload needs no reset; only the valid flag does.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_in_ready) begin
            r_in_vld <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_ready && i_req.valid) begin
            r_in.req_type  <= i_req.req_type;
            r_in.ack_valid <= i_req.ack_valid;
            r_in.ack_type  <= i_req.ack_type;
            r_in.ack_seq   <= i_req.ack_seq;
        end
    end

    // Output register, loaded with the result in the same cycle as the state
    // update so that result order always follows request order.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_step) begin
            r_out_vld <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out <= w_res;
        end
    end

    assign o_rsp.valid       = r_out_vld;
    assign o_rsp.send_valid  = r_out.send_valid;
    assign o_rsp.send_seq    = r_out.send_seq;
    assign o_rsp.send_offset = r_out.send_offset;
    assign o_rsp.send_length = r_out.send_length;
    assign o_rsp.timed_out   = r_out.timed_out;
    assign o_rsp.finished    = r_out.finished;
    assign o_rsp.end_seq     = r_out.end_seq;

endmodule
